[rtl/core/lmfb_pkg.sv]
// ----------------------------------------------------------------------------
// lmfb_pkg
// Shared types and constants of the LED matrix framebuffer: item and result
// codes, register indexes, controller states and line RAM control.
// ----------------------------------------------------------------------------
package lmfb_pkg;

    localparam int MOD_SIDE   = 8;
    localparam int LINE_W     = 3;
    localparam int ROW_W      = 8;
    localparam int COORD_IN_W = 16;
    localparam int MOD_NUM_W  = 5;
    localparam int DIGIT_W    = 4;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;

    localparam logic [DIGIT_W-1:0] DIGIT_BASE = 4'd8;
    localparam logic [LINE_W-1:0]  LAST_LINE  = 3'd7;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE       = 2'd0,
        KIND_READ        = 2'd1,
        KIND_RENDER_MOD  = 2'd2,
        KIND_RENDER_LINE = 2'd3
    } kind_t;

    typedef enum logic {
        RES_CMD   = 1'b0,
        RES_PIXEL = 1'b1
    } res_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AUTO_RENDER = 1'b0,
        REG_CLIP_ENABLE = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QUOT,
        ST_REM,
        ST_PIX_RD,
        ST_PIX_UPD,
        ST_LINE_RD,
        ST_LINE_OUT
    } state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } ram_ctl_t;

endpackage

[rtl/core/lmfb_req_if.sv]
// ----------------------------------------------------------------------------
// lmfb_req_if
// Request channel: one beat carries one pixel or render item.
// ----------------------------------------------------------------------------
interface lmfb_req_if
    import lmfb_pkg::*;
();

    logic                         valid;
    logic                         ready;
    logic [KIND_W-1:0]            kind;
    logic signed [COORD_IN_W-1:0] pos_x;
    logic signed [COORD_IN_W-1:0] pos_y;
    logic                         pixel_in;
    logic [MOD_NUM_W-1:0]         module_sel;
    logic [LINE_W-1:0]            line_sel;

    modport source (
        output valid, kind, pos_x, pos_y, pixel_in, module_sel, line_sel,
        input  ready
    );

    modport sink (
        input  valid, kind, pos_x, pos_y, pixel_in, module_sel, line_sel,
        output ready
    );

endinterface

[rtl/core/lmfb_rsp_if.sv]
// ----------------------------------------------------------------------------
// lmfb_rsp_if
// Result channel: one beat carries a module line command or pixel read data.
// ----------------------------------------------------------------------------
interface lmfb_rsp_if
    import lmfb_pkg::*;
();

    logic                 valid;
    logic                 ready;
    logic                 result_kind;
    logic [MOD_NUM_W-1:0] module_out;
    logic [DIGIT_W-1:0]   digit_reg;
    logic [ROW_W-1:0]     row_bits;
    logic                 pixel_out;
    logic                 last;

    modport source (
        output valid, result_kind, module_out, digit_reg, row_bits, pixel_out, last,
        input  ready
    );

    modport sink (
        input  valid, result_kind, module_out, digit_reg, row_bits, pixel_out, last,
        output ready
    );

endinterface

[rtl/core/led_matrix_framebuffer_top.sv]
// ----------------------------------------------------------------------------
// led_matrix_framebuffer_top
// One-bit framebuffer over a grid of 8x8 LED modules with line commands.
// ----------------------------------------------------------------------------
// After reset the line store is cleared one entry a cycle (MODS_X*MODS_Y*8
// entries, 128 at the default size); no request beat is taken during that
// pass, configuration writes are. Items are handled one at a time. A pixel
// write or read steps through ST_QUOT and ST_REM (reciprocal-multiply
// coordinate wrapping), ST_PIX_RD (line RAM read) and ST_PIX_UPD, which
// writes the line back and/or loads the result register, before ready
// returns. A render line item runs ST_LINE_RD, then ST_LINE_OUT; a render
// module item does so for each of its eight lines. A clipped write or a
// render of an invalid module frees the port in the next cycle and yields
// no beat. The result register parts the sides; an untaken result stalls the item.
// ----------------------------------------------------------------------------
module led_matrix_framebuffer_top
    import lmfb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 32,
    parameter int SCREEN_HEIGHT = 32,
    parameter int MODULE_COUNT  = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    lmfb_req_if.sink              req,
    lmfb_rsp_if.source            rsp
);

    localparam int MODS_X = (SCREEN_WIDTH + MOD_SIDE - 1) / MOD_SIDE;
    localparam int MODS_Y = (SCREEN_HEIGHT + MOD_SIDE - 1) / MOD_SIDE;
    localparam int DEPTH  = MODS_X * MODS_Y * MOD_SIDE;
    localparam int AW     = $clog2(DEPTH);
    localparam int XW     = ($clog2(SCREEN_WIDTH) > LINE_W) ? $clog2(SCREEN_WIDTH) : LINE_W + 1;
    localparam int YW     = ($clog2(SCREEN_HEIGHT) > LINE_W) ? $clog2(SCREEN_HEIGHT) : LINE_W + 1;

    logic             coord_load;
    logic [XW-1:0]    x_wrapped;
    logic [YW-1:0]    y_wrapped;
    ram_ctl_t         ram_ctl;
    logic [AW-1:0]    ram_addr;
    logic [ROW_W-1:0] ram_wdata;
    logic [ROW_W-1:0] ram_rdata;

    lmfb_wrap #(
        .N  (SCREEN_WIDTH),
        .CW (XW)
    ) u_wrap_x (
        .clk   (clk),
        .load  (coord_load),
        .pos   (req.pos_x),
        .coord (x_wrapped)
    );

    lmfb_wrap #(
        .N  (SCREEN_HEIGHT),
        .CW (YW)
    ) u_wrap_y (
        .clk   (clk),
        .load  (coord_load),
        .pos   (req.pos_y),
        .coord (y_wrapped)
    );

    lmfb_line_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_line_ram (
        .clk   (clk),
        .ctl   (ram_ctl),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    lmfb_seq #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .MODULE_COUNT  (MODULE_COUNT),
        .MODS_X        (MODS_X),
        .DEPTH         (DEPTH),
        .AW            (AW),
        .XW            (XW),
        .YW            (YW)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req        (req),
        .rsp        (rsp),
        .coord_load (coord_load),
        .x          (x_wrapped),
        .y          (y_wrapped),
        .ram_ctl    (ram_ctl),
        .ram_addr   (ram_addr),
        .ram_wdata  (ram_wdata),
        .ram_rdata  (ram_rdata)
    );

endmodule

[rtl/core/lmfb_line_ram.sv]
// ----------------------------------------------------------------------------
// lmfb_line_ram
// Single-port line store, one 8-bit module line per entry, registered read.
// ----------------------------------------------------------------------------
module lmfb_line_ram
    import lmfb_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int AW    = 7
)
(
    input  logic             clk,
    input  ram_ctl_t         ctl,
    input  logic [AW-1:0]    addr,
    input  logic [ROW_W-1:0] wdata,
    output logic [ROW_W-1:0] rdata
);

    logic [ROW_W-1:0] mem [DEPTH];
    logic [ROW_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= wdata;
        end
    end

    // Hold read data until the next read.
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/lmfb_wrap.sv]
// ----------------------------------------------------------------------------
// lmfb_wrap
// Signed coordinate to screen coordinate, true modulo N, in two stages:
// reciprocal multiply for the quotient, then multiply back and subtract.
// ----------------------------------------------------------------------------
module lmfb_wrap
    import lmfb_pkg::*;
#(
    parameter int N  = 32,
    parameter int CW = 5
)
(
    input  logic                  clk,
    input  logic                  load,
    input  logic [COORD_IN_W-1:0] pos,
    output logic [CW-1:0]         coord
);

    localparam int UW     = COORD_IN_W + 1;
    localparam int HALF   = 2 ** (COORD_IN_W - 1);
    localparam int OFFSET = N * ((HALF + N - 1) / N);
    localparam int SHIFT  = UW + $clog2(N);
    localparam int RW     = SHIFT - $clog2(N) + 2;
    localparam int PW     = UW + RW;
    localparam int QW     = PW - SHIFT;
    localparam logic [RW-1:0] RECIP = RW'((2 ** SHIFT + N - 1) / N);

    logic [UW-1:0] u_reg;
    logic [QW-1:0] q_reg;
    logic [CW-1:0] coord_reg;
    logic [PW-1:0] prod;
    logic [UW-1:0] rem_full;

    // Bias by a multiple of N so the value is never negative.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            u_reg <= {pos[COORD_IN_W-1], pos} + UW'(OFFSET);
        end
    end

    assign prod = PW'(u_reg) * PW'(RECIP);

    always_ff @(posedge clk)
    begin
        q_reg <= prod[PW-1:SHIFT];
    end

    assign rem_full = u_reg - UW'(q_reg) * UW'(N);

    always_ff @(posedge clk)
    begin
        coord_reg <= CW'(rem_full);
    end

    assign coord = coord_reg;

endmodule

[rtl/core/lmfb_seq.sv]
// ----------------------------------------------------------------------------
// lmfb_seq
// Item sequencer: configuration registers, store clearing pass, pixel
// read-modify-write, render line reads and the result register.
// ----------------------------------------------------------------------------
module lmfb_seq
    import lmfb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 32,
    parameter int SCREEN_HEIGHT = 32,
    parameter int MODULE_COUNT  = 16,
    parameter int MODS_X        = 4,
    parameter int DEPTH         = 128,
    parameter int AW            = 7,
    parameter int XW            = 5,
    parameter int YW            = 5
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    lmfb_req_if.sink              req,
    lmfb_rsp_if.source            rsp,
    output logic                  coord_load,
    input  logic [XW-1:0]         x,
    input  logic [YW-1:0]         y,
    output ram_ctl_t              ram_ctl,
    output logic [AW-1:0]         ram_addr,
    output logic [ROW_W-1:0]      ram_wdata,
    input  logic [ROW_W-1:0]      ram_rdata
);

    localparam int MOD_IDX_W = 8;
    localparam int REN_W     = MOD_NUM_W + LINE_W;
    localparam int CMP_W     = 10;

    state_t state_reg, state_next;

    logic                 auto_render_reg;
    logic                 clip_enable_reg;
    logic [AW-1:0]        clr_cnt_reg;
    kind_t                kind_reg;
    logic                 pixel_reg;
    logic [MOD_NUM_W-1:0] msel_reg;
    logic [LINE_W-1:0]    line_reg;
    logic [AW-1:0]        addr_reg;
    logic                 in_range_reg;

    logic                 rsp_valid_reg;
    res_kind_t            res_kind_reg;
    logic [MOD_NUM_W-1:0] mod_out_reg;
    logic [DIGIT_W-1:0]   digit_out_reg;
    logic [ROW_W-1:0]     row_out_reg;
    logic                 pix_out_reg;
    logic                 last_out_reg;

    logic                 req_fire;
    logic                 slot_free;
    logic                 clip_hit;
    logic                 msel_ok;
    logic                 clr_last;
    logic                 line_last;
    logic [MOD_IDX_W-1:0] mod0;
    logic [AW-1:0]        pix_idx;
    logic [REN_W-1:0]     ren_idx;
    logic                 ren_in_range;
    logic [ROW_W-1:0]     bit_mask;
    logic [ROW_W-1:0]     row_new;

    logic                 emit;
    res_kind_t            emit_kind;
    logic [MOD_NUM_W-1:0] emit_module;
    logic [DIGIT_W-1:0]   emit_digit;
    logic [ROW_W-1:0]     emit_row;
    logic                 emit_pixel;
    logic                 emit_last;

    assign req_fire   = req.valid && (state_reg == ST_IDLE);
    assign coord_load = req_fire;
    assign slot_free  = !rsp_valid_reg || rsp.ready;

    assign clip_hit = req.pos_x[COORD_IN_W-1]
        || ($unsigned(req.pos_x) >= COORD_IN_W'(SCREEN_WIDTH))
        || req.pos_y[COORD_IN_W-1]
        || ($unsigned(req.pos_y) >= COORD_IN_W'(SCREEN_HEIGHT));

    assign msel_ok = (req.module_sel != '0)
        && (MOD_IDX_W'(req.module_sel) <= MOD_IDX_W'(MODULE_COUNT));

    assign clr_last  = (clr_cnt_reg == AW'(DEPTH - 1));
    assign line_last = (kind_reg == KIND_RENDER_LINE) || (line_reg == LAST_LINE);

    // Module number from zero, then line inside the module.
    assign mod0    = MOD_IDX_W'(x >> LINE_W) + MOD_IDX_W'(y >> LINE_W) * MOD_IDX_W'(MODS_X);
    assign pix_idx = AW'({mod0, y[LINE_W-1:0]});

    assign ren_idx      = {msel_reg - MOD_NUM_W'(1), line_reg};
    assign ren_in_range = (CMP_W'(ren_idx) < CMP_W'(DEPTH));

    assign bit_mask = ROW_W'(1) << x[LINE_W-1:0];
    assign row_new  = pixel_reg ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_render_reg <= 1'b1;
            clip_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_AUTO_RENDER: auto_render_reg <= cfg_data[0];
                REG_CLIP_ENABLE: clip_enable_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    case (kind_t'(req.kind))
                        KIND_WRITE:
                        begin
                            // Drop an off-screen write right here.
                            state_next = (clip_enable_reg && clip_hit) ? ST_IDLE : ST_QUOT;
                        end
                        KIND_READ:
                        begin
                            state_next = ST_QUOT;
                        end
                        default:
                        begin
                            state_next = msel_ok ? ST_LINE_RD : ST_IDLE;
                        end
                    endcase
                end
            end
            ST_QUOT:
            begin
                state_next = ST_REM;
            end
            ST_REM:
            begin
                state_next = ST_PIX_RD;
            end
            ST_PIX_RD:
            begin
                state_next = ST_PIX_UPD;
            end
            ST_PIX_UPD:
            begin
                if (kind_reg == KIND_READ)
                begin
                    if (slot_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (!auto_render_reg || slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LINE_RD:
            begin
                state_next = ST_LINE_OUT;
            end
            ST_LINE_OUT:
            begin
                if (slot_free)
                begin
                    state_next = line_last ? ST_IDLE : ST_LINE_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.ready   = 1'b0;
        ram_ctl     = '0;
        ram_addr    = addr_reg;
        ram_wdata   = row_new;
        emit        = 1'b0;
        emit_kind   = RES_CMD;
        emit_module = '0;
        emit_digit  = '0;
        emit_row    = '0;
        emit_pixel  = 1'b0;
        emit_last   = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_ctl.wr_en = 1'b1;
                ram_addr      = clr_cnt_reg;
                ram_wdata     = '0;
            end
            ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            ST_PIX_RD:
            begin
                ram_ctl.rd_en = 1'b1;
                ram_addr      = pix_idx;
            end
            ST_PIX_UPD:
            begin
                if (kind_reg == KIND_READ)
                begin
                    emit       = slot_free;
                    emit_kind  = RES_PIXEL;
                    emit_pixel = ram_rdata[x[LINE_W-1:0]];
                end
                else
                begin
                    // Write back together with the command so it goes once.
                    ram_ctl.wr_en = !auto_render_reg || slot_free;
                    emit          = auto_render_reg && slot_free;
                    emit_module   = MOD_NUM_W'(addr_reg >> LINE_W) + MOD_NUM_W'(1);
                    emit_digit    = DIGIT_BASE - DIGIT_W'(addr_reg[LINE_W-1:0]);
                    emit_row      = row_new;
                end
            end
            ST_LINE_RD:
            begin
                ram_ctl.rd_en = ren_in_range;
                ram_addr      = AW'(ren_idx);
            end
            ST_LINE_OUT:
            begin
                emit        = slot_free;
                emit_module = msel_reg;
                emit_digit  = DIGIT_BASE - DIGIT_W'(line_reg);
                emit_row    = in_range_reg ? ram_rdata : '0;
                emit_last   = line_last;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            kind_reg  <= kind_t'(req.kind);
            pixel_reg <= req.pixel_in;
            msel_reg  <= req.module_sel;
            line_reg  <= (kind_t'(req.kind) == KIND_RENDER_LINE) ? req.line_sel : '0;
        end
        else if ((state_reg == ST_LINE_OUT) && emit && !line_last)
        begin
            line_reg <= line_reg + LINE_W'(1);
        end
        if (state_reg == ST_PIX_RD)
        begin
            addr_reg <= pix_idx;
        end
        if (state_reg == ST_LINE_RD)
        begin
            in_range_reg <= ren_in_range;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_kind_reg  <= emit_kind;
            mod_out_reg   <= emit_module;
            digit_out_reg <= emit_digit;
            row_out_reg   <= emit_row;
            pix_out_reg   <= emit_pixel;
            last_out_reg  <= emit_last;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.result_kind = res_kind_reg;
    assign rsp.module_out  = mod_out_reg;
    assign rsp.digit_reg   = digit_out_reg;
    assign rsp.row_bits    = row_out_reg;
    assign rsp.pixel_out   = pix_out_reg;
    assign rsp.last        = last_out_reg;

endmodule

[rtl/core/lmfb_checker.sv]
// ----------------------------------------------------------------------------
// lmfb_checker
// Port-level checks on the framebuffer result channel, bound to the top.
// ----------------------------------------------------------------------------
module lmfb_checker
    import lmfb_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 rsp_valid,
    input logic                 rsp_ready,
    input logic                 rsp_result_kind,
    input logic [MOD_NUM_W-1:0] rsp_module_out,
    input logic [DIGIT_W-1:0]   rsp_digit_reg,
    input logic [ROW_W-1:0]     rsp_row_bits,
    input logic                 rsp_pixel_out,
    input logic                 rsp_last
);

    a_rsp_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid
    ) else $error("result beat dropped while stalled");

    a_rsp_stable: assert property (
        @(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_result_kind) && $stable(rsp_module_out)
            && $stable(rsp_digit_reg) && $stable(rsp_row_bits)
            && $stable(rsp_pixel_out) && $stable(rsp_last)
    ) else $error("result payload changed while stalled");

    a_read_shape: assert property (
        @(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_result_kind == RES_PIXEL) |->
            (rsp_module_out == '0) && (rsp_digit_reg == '0) && (rsp_row_bits == '0)
            && rsp_last
    ) else $error("pixel read beat carries command fields");

    a_cmd_shape: assert property (
        @(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_result_kind == RES_CMD) |->
            (rsp_digit_reg != '0) && (rsp_digit_reg <= DIGIT_BASE) && !rsp_pixel_out
            && (rsp_module_out != '0)
    ) else $error("command beat out of range");

endmodule

bind led_matrix_framebuffer_top lmfb_checker u_lmfb_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_result_kind (rsp.result_kind),
    .rsp_module_out  (rsp.module_out),
    .rsp_digit_reg   (rsp.digit_reg),
    .rsp_row_bits    (rsp.row_bits),
    .rsp_pixel_out   (rsp.pixel_out),
    .rsp_last        (rsp.last)
);

[tb/sv/tb_led_matrix_framebuffer_top.sv]
// ----------------------------------------------------------------------------
// tb_led_matrix_framebuffer_top
// Self-checking bench for the LED matrix framebuffer. A scoreboard class keeps
// its own copy of the line store and registers. It predicts the command and
// read beats of every accepted request and checks each result beat in order.
// A directed pass covers coordinate extremes, wrapping, clipping and invalid
// modules. Random items then run under four pacing phases and several register
// settings.
// ----------------------------------------------------------------------------
module tb_led_matrix_framebuffer_top
    import lmfb_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCREEN_W       = 32;
    localparam int SCREEN_H       = 32;
    localparam int MODULE_CNT     = 16;
    localparam int MODS_X         = (SCREEN_W + MOD_SIDE - 1) / MOD_SIDE;
    localparam int MODS_Y         = (SCREEN_H + MOD_SIDE - 1) / MOD_SIDE;
    localparam int STORE_DEPTH    = MODS_X * MODS_Y * MOD_SIDE;
    localparam int SETTLE_CYCLES  = 24;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 44;

    typedef struct {
        kind_t                        kind;
        logic signed [COORD_IN_W-1:0] pos_x;
        logic signed [COORD_IN_W-1:0] pos_y;
        logic                         pixel_in;
        logic [MOD_NUM_W-1:0]         module_sel;
        logic [LINE_W-1:0]            line_sel;
    } fb_item_t;

    typedef struct {
        logic                 result_kind;
        logic [MOD_NUM_W-1:0] module_out;
        logic [DIGIT_W-1:0]   digit_reg;
        logic [ROW_W-1:0]     row_bits;
        logic                 pixel_out;
        logic                 last;
    } fb_beat_t;

    class fb_scoreboard;
        logic [ROW_W-1:0] line_mem [STORE_DEPTH];
        logic             auto_on;
        logic             clip_on;
        fb_beat_t         pending [$];
        int               errors;
        int               beats;

        function new();
            foreach (line_mem[i])
                line_mem[i] = '0;
            auto_on = 1'b1;
            clip_on = 1'b0;
            errors  = 0;
            beats   = 0;
        endfunction

        function void set_reg(cfg_reg_t r, logic v);
            if (r == REG_AUTO_RENDER)
                auto_on = v;
            else
                clip_on = v;
        endfunction

        function int wrap_coord(int v, int n);
            int r;
            r = v % n;
            if (r < 0)
                r += n;
            return r;
        endfunction

        function void queue_line_cmd(int mod_num, int ln, logic fin);
            fb_beat_t cmd;
            int       slot;
            slot            = (mod_num - 1) * MOD_SIDE + ln;
            cmd.result_kind = RES_CMD;
            cmd.module_out  = MOD_NUM_W'(mod_num);
            cmd.digit_reg   = DIGIT_BASE - DIGIT_W'(ln);
            cmd.row_bits    = (slot < STORE_DEPTH) ? line_mem[slot] : '0;
            cmd.pixel_out   = 1'b0;
            cmd.last        = fin;
            pending.push_back(cmd);
        endfunction

        // Apply one accepted request to the shadow store and queue its beats.
        function void note_item(fb_item_t it);
            int         sx;
            int         sy;
            int         cx;
            int         cy;
            int         slot;
            logic [7:0] mask;
            fb_beat_t   rd;
            sx   = int'($signed(it.pos_x));
            sy   = int'($signed(it.pos_y));
            cx   = wrap_coord(sx, SCREEN_W);
            cy   = wrap_coord(sy, SCREEN_H);
            slot = (cx / MOD_SIDE + (cy / MOD_SIDE) * MODS_X) * MOD_SIDE + cy % MOD_SIDE;
            mask = 8'd1 << (cx % MOD_SIDE);
            case (it.kind)
                KIND_WRITE:
                begin
                    if (clip_on && (sx < 0 || sx >= SCREEN_W || sy < 0 || sy >= SCREEN_H))
                        return;
                    if (it.pixel_in)
                        line_mem[slot] = line_mem[slot] | mask;
                    else
                        line_mem[slot] = line_mem[slot] & ~mask;
                    if (auto_on)
                        queue_line_cmd(slot / MOD_SIDE + 1, slot % MOD_SIDE, 1'b1);
                end
                KIND_READ:
                begin
                    rd.result_kind = RES_PIXEL;
                    rd.module_out  = '0;
                    rd.digit_reg   = '0;
                    rd.row_bits    = '0;
                    rd.pixel_out   = |(line_mem[slot] & mask);
                    rd.last        = 1'b1;
                    pending.push_back(rd);
                end
                default:
                begin
                    if (it.module_sel < 1 || it.module_sel > MODULE_CNT)
                        return;
                    if (it.kind == KIND_RENDER_LINE)
                        queue_line_cmd(it.module_sel, it.line_sel, 1'b1);
                    else
                        for (int i = 0; i < MOD_SIDE; i++)
                            queue_line_cmd(it.module_sel, i, i == MOD_SIDE - 1);
                end
            endcase
        endfunction

        function void cmp_field(string name, int exp_val, int got_val);
            if (exp_val != got_val)
            begin
                errors++;
                $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h",
                         $time, name, exp_val, got_val);
            end
        endfunction

        function void check_beat(fb_beat_t got);
            fb_beat_t exp_beat;
            beats++;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat, kind %0d module %0d row 0x%0h",
                         $time, got.result_kind, got.module_out, got.row_bits);
                return;
            end
            exp_beat = pending.pop_front();
            cmp_field("result_kind", exp_beat.result_kind, got.result_kind);
            cmp_field("module_out", exp_beat.module_out, got.module_out);
            cmp_field("digit_reg", exp_beat.digit_reg, got.digit_reg);
            cmp_field("row_bits", exp_beat.row_bits, got.row_bits);
            cmp_field("pixel_out", exp_beat.pixel_out, got.pixel_out);
            cmp_field("last", exp_beat.last, got.last);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lmfb_req_if req_ch ();
    lmfb_rsp_if rsp_ch ();

    fb_scoreboard sb;
    fb_beat_t     seen_beat;
    int           gap_pct;
    int           stall_pct;
    int           items_sent;
    int           reg_writes;
    int           quiet_cycles;

    led_matrix_framebuffer_top #(
        .SCREEN_WIDTH  (SCREEN_W),
        .SCREEN_HEIGHT (SCREEN_H),
        .MODULE_COUNT  (MODULE_CNT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            seen_beat.result_kind = rsp_ch.result_kind;
            seen_beat.module_out  = rsp_ch.module_out;
            seen_beat.digit_reg   = rsp_ch.digit_reg;
            seen_beat.row_bits    = rsp_ch.row_bits;
            seen_beat.pixel_out   = rsp_ch.pixel_out;
            seen_beat.last        = rsp_ch.last;
            sb.check_beat(seen_beat);
        end
    end

    // Count cycles with no beat on either side.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, sb.pending.size());
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic fb_item_t make_item(kind_t k, int x, int y, logic pix,
                                           int msel, int lsel);
        fb_item_t it;
        it.kind       = k;
        it.pos_x      = COORD_IN_W'(x);
        it.pos_y      = COORD_IN_W'(y);
        it.pixel_in   = pix;
        it.module_sel = MOD_NUM_W'(msel);
        it.line_sel   = LINE_W'(lsel);
        return it;
    endfunction

    // Mostly on-screen, some just off the edges, a few anywhere in 16 bits.
    function automatic logic [COORD_IN_W-1:0] rand_coord(int span);
        int pick;
        int v;
        pick = $urandom_range(99);
        if (pick < 65)
            v = $urandom_range(span - 1);
        else if (pick < 85)
            v = int'($urandom_range(span + 16)) - 8;
        else
            v = $urandom();
        return COORD_IN_W'(v);
    endfunction

    function automatic fb_item_t rand_item();
        fb_item_t it;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 50)
            it.kind = KIND_WRITE;
        else if (pick < 68)
            it.kind = KIND_READ;
        else if (pick < 80)
            it.kind = KIND_RENDER_MOD;
        else
            it.kind = KIND_RENDER_LINE;
        it.pos_x    = rand_coord(SCREEN_W);
        it.pos_y    = rand_coord(SCREEN_H);
        it.pixel_in = 1'($urandom_range(1));
        if ($urandom_range(99) < 85)
            it.module_sel = MOD_NUM_W'($urandom_range(MODULE_CNT, 1));
        else
            it.module_sel = MOD_NUM_W'($urandom_range(31));
        it.line_sel = LINE_W'($urandom_range(7));
        return it;
    endfunction

    task automatic send_item(input fb_item_t it);
        while ($urandom_range(99) < gap_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.kind       <= it.kind;
        req_ch.pos_x      <= it.pos_x;
        req_ch.pos_y      <= it.pos_y;
        req_ch.pixel_in   <= it.pixel_in;
        req_ch.module_sel <= it.module_sel;
        req_ch.line_sel   <= it.line_sel;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_item(it);
        items_sent++;
    endtask

    // Hold the request side until every predicted beat has come back.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic auto_val, input logic clip_val);
        cfg_we    <= 1'b1;
        cfg_index <= REG_AUTO_RENDER;
        cfg_data  <= auto_val;
        @(posedge clk);
        cfg_index <= REG_CLIP_ENABLE;
        cfg_data  <= clip_val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(REG_AUTO_RENDER, auto_val);
        sb.set_reg(REG_CLIP_ENABLE, clip_val);
        reg_writes += 2;
    endtask

    initial
    begin
        int           phase_gap [4];
        int           phase_stall [4];
        logic         phase_auto [4];
        logic         phase_clip [4];

        phase_gap         = '{0, 57, 0, 27};
        phase_stall       = '{0, 0, 57, 27};
        phase_auto        = '{1'b1, 1'b1, 1'b0, 1'b1};
        phase_clip        = '{1'b0, 1'b1, 1'b1, 1'b0};
        sb                = new();
        clk               = 1'b0;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_AUTO_RENDER;
        cfg_data          = '0;
        req_ch.valid      = 1'b0;
        req_ch.kind       = KIND_WRITE;
        req_ch.pos_x      = '0;
        req_ch.pos_y      = '0;
        req_ch.pixel_in   = 1'b0;
        req_ch.module_sel = '0;
        req_ch.line_sel   = '0;
        rsp_ch.ready      = 1'b0;
        gap_pct           = 0;
        stall_pct         = 0;
        items_sent        = 0;
        reg_writes        = 0;
        quiet_cycles      = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Written during the clearing pass; both at their reset values.
        set_config(1'b1, 1'b0);

        // Corners, 16-bit extremes, negative wrap, then reads and valid renders.
        send_item(make_item(KIND_WRITE, 0, 0, 1'b1, 0, 0));
        send_item(make_item(KIND_WRITE, 31, 31, 1'b1, 0, 0));
        send_item(make_item(KIND_WRITE, -32768, 32767, 1'b1, 0, 0));
        send_item(make_item(KIND_WRITE, 32767, -32768, 1'b1, 0, 0));
        send_item(make_item(KIND_WRITE, -1, -9, 1'b1, 31, 7));
        send_item(make_item(KIND_WRITE, 0, 0, 1'b0, 0, 0));
        send_item(make_item(KIND_READ, 0, 0, 1'b0, 0, 0));
        send_item(make_item(KIND_READ, -1, -1, 1'b1, 0, 0));
        send_item(make_item(KIND_RENDER_MOD, 0, 0, 1'b0, 1, 0));
        send_item(make_item(KIND_RENDER_MOD, 0, 0, 1'b0, MODULE_CNT, 0));
        send_item(make_item(KIND_RENDER_LINE, 0, 0, 1'b0, 4, 0));
        send_item(make_item(KIND_RENDER_LINE, 0, 0, 1'b0, 13, 7));
        // Invalid module numbers produce nothing.
        send_item(make_item(KIND_RENDER_MOD, 0, 0, 1'b0, 0, 0));
        send_item(make_item(KIND_RENDER_LINE, 0, 0, 1'b0, MODULE_CNT + 1, 3));
        send_item(make_item(KIND_RENDER_MOD, 0, 0, 1'b0, 31, 0));
        wait_drained();

        // Clipping drops off-screen writes; reads still wrap.
        set_config(1'b1, 1'b1);
        send_item(make_item(KIND_WRITE, 32, 0, 1'b1, 0, 0));
        send_item(make_item(KIND_WRITE, -1, 5, 1'b1, 0, 0));
        send_item(make_item(KIND_WRITE, 4, 32, 1'b1, 0, 0));
        send_item(make_item(KIND_WRITE, 4, -32768, 1'b1, 0, 0));
        send_item(make_item(KIND_WRITE, 7, 7, 1'b1, 0, 0));
        send_item(make_item(KIND_READ, -25, -25, 1'b0, 0, 0));
        wait_drained();

        // Auto-render off: the write is stored silently, then rendered.
        set_config(1'b0, 1'b0);
        send_item(make_item(KIND_WRITE, -3, 40, 1'b1, 0, 0));
        send_item(make_item(KIND_RENDER_LINE, 0, 0, 1'b0, 8, 0));
        send_item(make_item(KIND_READ, 29, 8, 1'b0, 0, 0));
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            set_config(phase_auto[ph], phase_clip[ph]);
            gap_pct   = phase_gap[ph];
            stall_pct = phase_stall[ph];
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 1 && n == PHASE_ITEMS / 2)
                    wait_drained();
                send_item(rand_item());
            end
            wait_drained();
        end

        stall_pct = 0;
        wait_drained();

        $display("Sent %0d requests and checked %0d result beats across four pacing phases,",
                 items_sent, sb.beats);
        $display("with %0d register writes covering wrap, clip and auto-render on/off.",
                 reg_writes);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
